// File: sv/lz4fd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz4fd_pkg
// shared types and constants of the lz4 frame decompressor
// ----------------------------------------------------------------------------
package lz4fd_pkg;

    localparam int WINDOW_BYTES_DEF    = 65536;
    localparam int MAX_BLOCK_BYTES_DEF = 4194304;
    localparam int LEN_W               = 23;
    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    typedef enum logic [3:0] {
        PH_MAGIC  = 4'd0,
        PH_FLG    = 4'd1,
        PH_BD     = 4'd2,
        PH_HSKIP  = 4'd3,
        PH_BSIZE  = 4'd4,
        PH_RAW    = 4'd5,
        PH_TOKEN  = 4'd6,
        PH_LITEXT = 4'd7,
        PH_LIT    = 4'd8,
        PH_OFF0   = 4'd9,
        PH_OFF1   = 4'd10,
        PH_MEXT   = 4'd11,
        PH_COPY   = 4'd12,
        PH_BCSUM  = 4'd13,
        PH_CCSUM  = 4'd14,
        PH_DONE   = 4'd15
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_VERSION = 3'd1,
        ERR_BSIZE   = 3'd2,
        ERR_LIT     = 3'd3,
        ERR_OFFSET  = 3'd4,
        ERR_MLEN    = 3'd5,
        ERR_REFUSED = 3'd6
    } err_t;

    localparam int FL_BCSUM = 0;
    localparam int FL_CLEN  = 1;
    localparam int FL_CCSUM = 2;
    localparam int FL_DICT  = 3;

    localparam logic FUNC_FEED  = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_SAT : s[LEN_W-1:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/lz4fd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz4fd_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module lz4fd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: sv/lz4_frame_decompressor.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lz4_frame_decompressor
// lz4 frame parser and block decoder with a 64 KiB history memory
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one item per handshake: tuser = func (0 feed a frame byte,
//   1 drain one pending match byte), tdata = frame byte.
//   m_axis returns exactly one result item for every accepted input item:
//   tdata = {error_code, frame_done, copy_pending, out_byte, out_valid}.
//   an item is processed when accepted and its result sits in the output
//   register the next cycle; one item per cycle is sustained while m_axis is not stalled.
//   a drain item reads the history ram through its registered port; the read
//   address is issued from the next-state logic, and a write to the same
//   entry in the same cycle is forwarded around the ram.
//   the input is taken whenever the output register is empty or is being
//   taken in the same cycle, so a stalled receiver holds off the sender.
//   reset returns to the magic phase with no errors; history needs no clear.
// ----------------------------------------------------------------------------
module lz4_frame_decompressor
    import lz4fd_pkg::*;
#(
    parameter int WINDOW_BYTES    = WINDOW_BYTES_DEF,
    parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // in_byte
    input  wire logic        s_axis_tuser,   // func
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // out_valid, out_byte, copy_pending,
                                             // frame_done, error_code, 2 zero bits
);

    localparam int AW = $clog2(WINDOW_BYTES);

    phase_t           phase_reg, phase_next;
    logic [3:0]       flags_reg, flags_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [LEN_W-1:0] maxb_reg, maxb_next;
    logic [31:0]      size_reg, size_next;
    logic [LEN_W-1:0] left_reg, left_next;
    logic [LEN_W-1:0] oc_reg, oc_next;
    logic [LEN_W-1:0] lit_reg, lit_next;
    logic [3:0]       nib_reg, nib_next;
    logic [15:0]      off_reg, off_next;
    logic [LEN_W-1:0] ml_reg, ml_next;
    logic [2:0]       err_reg, err_next;

    logic             ovld_reg;
    logic [15:0]      odata_reg;

    logic             acc;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [7:0]       wdata;
    logic [AW-1:0]    raddr;
    logic [7:0]       rdata;
    logic             fwd_reg;
    logic [7:0]       fwd_data_reg;
    logic [7:0]       hist_byte;
    logic             valid;
    logic [7:0]       ob;

    assign s_axis_tready = !ovld_reg || m_axis_tready;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = odata_reg;

    // read address of the byte the next drain would copy
    assign raddr     = oc_next[AW-1:0] - off_next;
    assign hist_byte = fwd_reg ? fwd_data_reg : rdata;

    lz4fd_ram #(.WIDTH(8), .DEPTH(WINDOW_BYTES)) u_hist (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        logic [7:0]       b;
        logic [2:0]       c;
        logic [LEN_W-1:0] len;
        logic [LEN_W+1:0] endv;
        logic             last;
        logic [LEN_W:0]   tot;
        logic [30:0]      s31;
        logic             do_lit;
        logic             do_match;
        logic             do_end;
        logic             do_after;
        logic [LEN_W-1:0] mlen;
        logic [LEN_W-1:0] lb;
        phase_next = phase_reg;
        flags_next = flags_reg;
        cnt_next   = cnt_reg;
        maxb_next  = maxb_reg;
        size_next  = size_reg;
        left_next  = left_reg;
        oc_next    = oc_reg;
        lit_next   = lit_reg;
        nib_next   = nib_reg;
        off_next   = off_reg;
        ml_next    = ml_reg;
        err_next   = err_reg;
        valid      = 1'b0;
        ob         = 8'd0;
        we         = 1'b0;
        wdata      = s_axis_tdata;
        waddr      = oc_reg[AW-1:0];
        b          = s_axis_tdata;
        c          = b[6:4];
        len        = '0;
        do_lit     = 1'b0;
        do_match   = 1'b0;
        do_end     = 1'b0;
        do_after   = 1'b0;
        mlen       = '0;
        lb         = left_reg - 1'b1;
        endv       = '0;
        last       = 1'b0;
        tot        = '0;
        s31        = size_reg[30:0];
        if (acc && err_reg == ERR_NONE)
        begin
            if (s_axis_tuser == FUNC_DRAIN)
            begin
                if (phase_reg == PH_COPY)
                begin
                    ob      = hist_byte;
                    valid   = 1'b1;
                    we      = 1'b1;
                    wdata   = hist_byte;
                    oc_next = oc_reg + 1'b1;
                    ml_next = ml_reg - 1'b1;
                    if (ml_reg == 1)
                    begin
                        phase_next = PH_TOKEN;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (cnt_reg == 4'd3)
                        begin
                            cnt_next   = '0;
                            phase_next = PH_FLG;
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    PH_FLG:
                    begin
                        if (b[7:6] != 2'd1)
                        begin
                            err_next = ERR_VERSION;
                        end
                        else
                        begin
                            flags_next = {b[0], b[2], b[3], b[4]};
                            phase_next = PH_BD;
                        end
                    end
                    PH_BD:
                    begin
                        if (c < 3'd4 ||
                            (32'h10000 << (2 * (c - 3'd4))) > 32'(MAX_BLOCK_BYTES))
                        begin
                            err_next = ERR_BSIZE;
                        end
                        else
                        begin
                            maxb_next  = LEN_W'(32'h10000 << (2 * (c - 3'd4)));
                            cnt_next   = 4'd1 + (flags_reg[FL_CLEN] ? 4'd8 : 4'd0)
                                         + (flags_reg[FL_DICT] ? 4'd4 : 4'd0);
                            phase_next = PH_HSKIP;
                        end
                    end
                    PH_HSKIP, PH_BCSUM:
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == 4'd1)
                        begin
                            phase_next = PH_BSIZE;
                            size_next  = '0;
                        end
                    end
                    PH_CCSUM:
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (cnt_reg == 4'd1)
                        begin
                            phase_next = PH_DONE;
                        end
                    end
                    PH_BSIZE:
                    begin
                        size_next = size_reg | (32'(b) << (8 * cnt_reg[1:0]));
                        if (cnt_reg == 4'd3)
                        begin
                            cnt_next = '0;
                            s31      = size_next[30:0];
                            if (size_next == 32'd0)
                            begin
                                if (flags_reg[FL_CCSUM])
                                begin
                                    phase_next = PH_CCSUM;
                                    cnt_next   = 4'd4;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                            else if (s31 > 31'(maxb_reg))
                            begin
                                err_next = ERR_BSIZE;
                            end
                            else
                            begin
                                left_next = s31[LEN_W-1:0];
                                if (size_next[31])
                                begin
                                    if (s31 == 31'd0)
                                    begin
                                        do_end = 1'b1;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RAW;
                                    end
                                end
                                else
                                begin
                                    oc_next    = '0;
                                    phase_next = PH_TOKEN;
                                end
                            end
                        end
                        else
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                    PH_RAW:
                    begin
                        ob        = b;
                        valid     = 1'b1;
                        left_next = lb;
                        if (lb == '0)
                        begin
                            do_end = 1'b1;
                        end
                    end
                    PH_TOKEN:
                    begin
                        left_next = lb;
                        nib_next  = b[3:0];
                        if (b[7:4] == 4'hF)
                        begin
                            if (lb == '0)
                            begin
                                err_next = ERR_LIT;
                            end
                            else
                            begin
                                lit_next   = LEN_W'(15);
                                phase_next = PH_LITEXT;
                            end
                        end
                        else
                        begin
                            do_lit = 1'b1;
                            len    = LEN_W'(b[7:4]);
                        end
                    end
                    PH_LITEXT:
                    begin
                        left_next = lb;
                        lit_next  = sat_add(lit_reg, LEN_W'(b));
                        if (!(lb > LEN_W'(15) && b == 8'hFF))
                        begin
                            do_lit = 1'b1;
                            len    = lit_next;
                        end
                    end
                    PH_LIT:
                    begin
                        ob        = b;
                        valid     = 1'b1;
                        we        = 1'b1;
                        oc_next   = oc_reg + 1'b1;
                        left_next = lb;
                        lit_next  = lit_reg - 1'b1;
                        if (lit_reg == 1)
                        begin
                            do_after = 1'b1;
                        end
                    end
                    PH_OFF0:
                    begin
                        left_next  = lb;
                        off_next   = {8'd0, b};
                        phase_next = PH_OFF1;
                    end
                    PH_OFF1:
                    begin
                        left_next = lb;
                        off_next  = {b, off_reg[7:0]};
                        if (off_next == 16'd0 || LEN_W'(off_next) > oc_reg)
                        begin
                            err_next = ERR_OFFSET;
                        end
                        else if (nib_reg == 4'hF)
                        begin
                            ml_next    = LEN_W'(15);
                            phase_next = PH_MEXT;
                        end
                        else
                        begin
                            do_match = 1'b1;
                            mlen     = LEN_W'(nib_reg);
                        end
                    end
                    PH_MEXT:
                    begin
                        left_next = lb;
                        if (lb < LEN_W'(5))
                        begin
                            err_next = ERR_MLEN;
                        end
                        else
                        begin
                            ml_next = sat_add(ml_reg, LEN_W'(b));
                            if (b != 8'hFF)
                            begin
                                do_match = 1'b1;
                                mlen     = ml_next;
                            end
                        end
                    end
                    PH_COPY:
                    begin
                        err_next = ERR_REFUSED;
                    end
                    default:
                    begin
                    end
                endcase

                if (do_lit)
                begin
                    endv = (LEN_W+2)'(oc_reg) + (LEN_W+2)'(len);
                    last = (endv + 12 > (LEN_W+2)'(maxb_reg)) ||
                           ((LEN_W+2)'(len) + 8 > (LEN_W+2)'(left_next));
                    if (last && (len != left_next || endv > (LEN_W+2)'(maxb_reg)))
                    begin
                        err_next = ERR_LIT;
                    end
                    else
                    begin
                        lit_next = len;
                        if (len == '0)
                        begin
                            do_after = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_LIT;
                        end
                    end
                end
                if (do_after)
                begin
                    if (left_next == '0)
                    begin
                        do_end = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_OFF0;
                    end
                end
                if (do_match)
                begin
                    mlen = sat_add(mlen, LEN_W'(4));
                    tot  = {1'b0, oc_reg} + {1'b0, mlen};
                    if (tot > {1'b0, maxb_reg})
                    begin
                        err_next = ERR_MLEN;
                    end
                    else
                    begin
                        ml_next    = mlen;
                        phase_next = PH_COPY;
                    end
                end
                if (do_end)
                begin
                    if (flags_reg[FL_BCSUM])
                    begin
                        phase_next = PH_BCSUM;
                        cnt_next   = 4'd4;
                    end
                    else
                    begin
                        phase_next = PH_BSIZE;
                        cnt_next   = '0;
                        size_next  = '0;
                    end
                end
            end
        end
        if (err_next != ERR_NONE)
        begin
            valid = 1'b0;
            we    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            flags_reg <= '0;
            cnt_reg   <= '0;
            maxb_reg  <= '0;
            size_reg  <= '0;
            left_reg  <= '0;
            oc_reg    <= '0;
            lit_reg   <= '0;
            nib_reg   <= '0;
            off_reg   <= '0;
            ml_reg    <= '0;
            err_reg   <= ERR_NONE;
            ovld_reg  <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
            maxb_reg  <= maxb_next;
            size_reg  <= size_next;
            left_reg  <= left_next;
            oc_reg    <= oc_next;
            lit_reg   <= lit_next;
            nib_reg   <= nib_next;
            off_reg   <= off_next;
            ml_reg    <= ml_next;
            err_reg   <= err_next;
            fwd_reg   <= we && (waddr == raddr);
            if (acc)
            begin
                ovld_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                ovld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= wdata;
        if (acc)
        begin
            odata_reg <= {2'b00, err_next,
                          (err_next == ERR_NONE && phase_next == PH_DONE),
                          (err_next == ERR_NONE && phase_next == PH_COPY),
                          (valid ? ob : 8'd0), valid};
        end
    end

endmodule
`default_nettype wire
